// File: rtl/srba_pkg.sv
// Package with the shared types, codes and constants of the bump allocator.
package srba_pkg;

   localparam int DefaultMaxBlocks   = 64;
   localparam int DefaultHeaderBytes = 32;
   localparam int PoolBits           = 24;
   localparam logic [PoolBits-1:0] PoolSizeReset = 24'd65536;

   typedef enum logic [1:0] {
      FUNC_ALLOC   = 2'd0,
      FUNC_CALLOC  = 2'd1,
      FUNC_REALLOC = 2'd2,
      FUNC_FREE    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OUTSIDE  = 2'd1,
      STATUS_NO_BLOCK = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SRC_NONE  = 2'd0,
      SRC_PLACE = 2'd1,
      SRC_FOUND = 2'd2
   } res_src_type;

   typedef struct packed {
      func_type      func;
      logic [23:0]   count;
      logic [23:0]   element_count;
      logic          has_pointer;
      logic [31:0]   ptr_offset;
   } req_type;

   typedef struct packed {
      logic [23:0]   result_offset;
      logic          result_null;
      status_type    status;
      logic          needs_clear;
   } rsp_type;

   typedef struct packed {
      logic          load;
      logic          scan_init;
      logic          scan_step;
      logic          hit_latch;
      logic          mark_free;
      logic          pop_init;
      logic          pop_rd;
      logic          pop_step;
      logic          pop_finish;
      logic          place;
      logic          grow;
      logic          res_set;
      res_src_type   res_src;
      status_type    res_status;
      logic          res_clear;
      logic          emit;
   } cmd_type;

   typedef struct packed {
      func_type      func;
      logic          has_ptr;
      logic          ptr_in_pool;
      logic          table_empty;
      logic          hit;
      logic          scan_last;
      logic          is_top;
      logic          size_same;
      logic          count_zero;
      logic          grow_fit;
      logic          place_fit;
      logic          pop_cnt_zero;
      logic          rd_use;
      logic          out_busy;
   } sts_type;

endpackage

// File: rtl/stack_reclaim_bump_allocator_unit.sv
// Top level of the bump allocator with tail reclaim: controller plus datapath.
// Alloc and calloc go from decode straight to placement; realloc with a pointer and free first
// scan the block table from the newest entry down, and freeing the top block adds a tail pop
// that also drops the freed entries below it and lowers the top of the pool.
// One transaction is in work at a time, and the next is taken only after its result has
// entered the output register; synchronous reset empties the pool and sets pool_size to 65536.
module stack_reclaim_bump_allocator_unit
   import srba_pkg::*;
#(
   parameter int MAX_BLOCKS   = DefaultMaxBlocks,
   parameter int HEADER_BYTES = DefaultHeaderBytes
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data
);

   cmd_type cmd;
   sts_type sts;

   srba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   srba_dp #(
      .MAX_BLOCKS   (MAX_BLOCKS),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// File: rtl/srba_ctrl.sv
// Controller state machine that sequences each allocator transaction.
module srba_ctrl
   import srba_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_ACT,
      S_POP_RD,
      S_POP_CHK,
      S_PLACE,
      S_DONE
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.res_src    = SRC_NONE;
      cmd.res_status = STATUS_OK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (sts.func == FUNC_ALLOC || sts.func == FUNC_CALLOC ||
                (sts.func == FUNC_REALLOC && !sts.has_ptr)) begin
               state_in = S_PLACE;
            end else if (!sts.has_ptr || !sts.ptr_in_pool) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_OUTSIDE;
               state_in       = S_DONE;
            end else if (sts.table_empty) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_NO_BLOCK;
               state_in       = S_DONE;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.hit) begin
               cmd.hit_latch = 1'b1;
               state_in      = S_ACT;
            end else if (sts.scan_last) begin
               cmd.res_set    = 1'b1;
               cmd.res_status = STATUS_NO_BLOCK;
               state_in       = S_DONE;
            end
         end
         S_ACT: begin
            if (sts.func == FUNC_FREE || sts.count_zero) begin
               if (sts.is_top) begin
                  cmd.pop_init = 1'b1;
                  state_in     = S_POP_RD;
               end else begin
                  cmd.mark_free = 1'b1;
                  cmd.res_set   = 1'b1;
                  state_in      = S_DONE;
               end
            end else if (sts.size_same) begin
               cmd.res_set = 1'b1;
               cmd.res_src = SRC_FOUND;
               state_in    = S_DONE;
            end else if (sts.is_top) begin
               cmd.res_set = 1'b1;
               if (sts.grow_fit) begin
                  cmd.grow    = 1'b1;
                  cmd.res_src = SRC_FOUND;
               end
               state_in = S_DONE;
            end else begin
               cmd.mark_free = 1'b1;
               state_in      = S_PLACE;
            end
         end
         S_POP_RD: begin
            if (sts.pop_cnt_zero) begin
               cmd.pop_finish = 1'b1;
               cmd.res_set    = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.pop_rd = 1'b1;
               state_in   = S_POP_CHK;
            end
         end
         S_POP_CHK: begin
            if (!sts.rd_use) begin
               cmd.pop_step = 1'b1;
               state_in     = S_POP_RD;
            end else begin
               cmd.pop_finish = 1'b1;
               cmd.res_set    = 1'b1;
               state_in       = S_DONE;
            end
         end
         S_PLACE: begin
            cmd.res_set = 1'b1;
            if (sts.place_fit) begin
               cmd.place     = 1'b1;
               cmd.res_src   = SRC_PLACE;
               cmd.res_clear = (sts.func == FUNC_CALLOC);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!sts.out_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/srba_dp.sv
// Datapath with the block table memory, top and count registers and output register.
module srba_dp
   import srba_pkg::*;
#(
   parameter int MAX_BLOCKS   = DefaultMaxBlocks,
   parameter int HEADER_BYTES = DefaultHeaderBytes
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [23:0] csr_write_data,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  cmd_type     cmd,
   output sts_type     sts
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam logic [49:0] Hdr50 = 50'(HEADER_BYTES);
   localparam logic [24:0] Hdr25 = 25'(HEADER_BYTES);

   logic [23:0] start_mem [MAX_BLOCKS];
   logic [23:0] size_mem  [MAX_BLOCKS];
   logic        use_mem   [MAX_BLOCKS];

   req_type          req_ff;
   logic [47:0]      n_ff, n_in;
   logic [23:0]      pool_ff;
   logic [23:0]      top_ff, top_in;
   logic [CNT_W-1:0] bcnt_ff, bcnt_in;
   logic [IDX_W-1:0] scan_ff, scan_in;
   logic             chk_v_ff, chk_v_in;
   logic [IDX_W-1:0] chk_idx_ff;
   logic [IDX_W-1:0] found_idx_ff;
   logic [23:0]      found_start_ff;
   logic [23:0]      found_size_ff;
   logic [IDX_W-1:0] pop_cnt_ff, pop_cnt_in;
   logic [23:0]      low_ff, low_in;
   rsp_type          res_ff, res_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic [23:0]      rd_start_ff;
   logic [23:0]      rd_size_ff;
   logic             rd_use_ff;

   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;
   logic [49:0]      place_sum;
   logic [24:0]      place_off;
   logic [24:0]      grow_sum;
   logic [24:0]      pop_top;

   assign place_sum = {26'd0, top_ff} + Hdr50 + {2'd0, n_ff};
   assign place_off = {1'b0, top_ff} + Hdr25;
   assign grow_sum  = {1'b0, found_start_ff} + {1'b0, req_ff.count};
   assign pop_top   = {1'b0, low_ff} - Hdr25;
   assign rd_addr   = cmd.pop_rd ? (pop_cnt_ff - IDX_W'(1)) : scan_ff;
   assign wr_addr   = cmd.place ? IDX_W'(bcnt_ff) : found_idx_ff;

   always_comb begin
      sts.func         = req_ff.func;
      sts.has_ptr      = req_ff.has_pointer;
      sts.ptr_in_pool  = req_ff.ptr_offset < {8'd0, pool_ff};
      sts.table_empty  = (bcnt_ff == '0);
      sts.hit          = chk_v_ff && rd_use_ff && ({8'd0, rd_start_ff} == req_ff.ptr_offset);
      sts.scan_last    = chk_v_ff && (chk_idx_ff == '0);
      sts.is_top       = (CNT_W'(found_idx_ff) + CNT_W'(1)) == bcnt_ff;
      sts.size_same    = (req_ff.count == found_size_ff);
      sts.count_zero   = (req_ff.count == '0);
      sts.grow_fit     = grow_sum < {1'b0, pool_ff};
      sts.place_fit    = (bcnt_ff < CNT_W'(MAX_BLOCKS)) && (place_sum < {26'd0, pool_ff});
      sts.pop_cnt_zero = (pop_cnt_ff == '0);
      sts.rd_use       = rd_use_ff;
      sts.out_busy     = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      n_in = n_ff;
      if (cmd.load) begin
         if (req_data.func == FUNC_CALLOC) begin
            n_in = {24'd0, req_data.count} * {24'd0, req_data.element_count};
         end else begin
            n_in = {24'd0, req_data.count};
         end
      end
   end

   always_comb begin
      top_in     = top_ff;
      bcnt_in    = bcnt_ff;
      scan_in    = scan_ff;
      chk_v_in   = chk_v_ff;
      pop_cnt_in = pop_cnt_ff;
      low_in     = low_ff;
      if (cmd.scan_init) begin
         scan_in  = IDX_W'(bcnt_ff - CNT_W'(1));
         chk_v_in = 1'b0;
      end else if (cmd.scan_step) begin
         scan_in  = scan_ff - IDX_W'(1);
         chk_v_in = 1'b1;
      end
      if (cmd.pop_init) begin
         pop_cnt_in = found_idx_ff;
         low_in     = found_start_ff;
      end else if (cmd.pop_step) begin
         pop_cnt_in = pop_cnt_ff - IDX_W'(1);
         low_in     = rd_start_ff;
      end
      if (cmd.pop_finish) begin
         bcnt_in = CNT_W'(pop_cnt_ff);
         top_in  = (pop_cnt_ff == '0) ? 24'd0 : pop_top[23:0];
      end else if (cmd.place) begin
         bcnt_in = bcnt_ff + CNT_W'(1);
         top_in  = place_sum[23:0];
      end else if (cmd.grow) begin
         top_in = grow_sum[23:0];
      end
   end

   always_comb begin
      res_in = res_ff;
      if (cmd.res_set) begin
         res_in.result_null = (cmd.res_src == SRC_NONE);
         res_in.status      = cmd.res_status;
         res_in.needs_clear = cmd.res_clear;
         case (cmd.res_src)
            SRC_PLACE: res_in.result_offset = place_off[23:0];
            SRC_FOUND: res_in.result_offset = found_start_ff;
            default:   res_in.result_offset = 24'd0;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff      <= PoolSizeReset;
         top_ff       <= '0;
         bcnt_ff      <= '0;
         chk_v_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            pool_ff <= csr_write_data;
         end
         top_ff       <= top_in;
         bcnt_ff      <= bcnt_in;
         chk_v_ff     <= chk_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff <= req_data;
      end
      n_ff       <= n_in;
      scan_ff    <= scan_in;
      pop_cnt_ff <= pop_cnt_in;
      low_ff     <= low_in;
      res_ff     <= res_in;
      if (cmd.scan_step) begin
         chk_idx_ff <= scan_ff;
      end
      if (cmd.hit_latch) begin
         found_idx_ff   <= chk_idx_ff;
         found_start_ff <= rd_start_ff;
         found_size_ff  <= rd_size_ff;
      end
      if (cmd.emit) begin
         rsp_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      rd_start_ff <= start_mem[rd_addr];
      rd_size_ff  <= size_mem[rd_addr];
      rd_use_ff   <= use_mem[rd_addr];
      if (cmd.place) begin
         start_mem[wr_addr] <= place_off[23:0];
         size_mem[wr_addr]  <= n_ff[23:0];
         use_mem[wr_addr]   <= 1'b1;
      end else if (cmd.grow) begin
         size_mem[wr_addr] <= req_ff.count;
      end else if (cmd.mark_free) begin
         use_mem[wr_addr] <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
